/* src/tmtc_pkg.sv */
package tmtc_pkg;

  localparam int unsigned MaxPointsDefault = 256;
  localparam logic [23:0] DefaultTempo     = 24'd500000;
  localparam logic [15:0] SmpteFlag        = 16'h8000;
  localparam logic [15:0] TpqReset         = 16'd96;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_T2US   = 3'd2,
    MODE_US2T   = 3'd3,
    MODE_TEMPO  = 3'd4
  } mode_e_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_ORDER   = 3'd2,
    ST_FULL    = 3'd3,
    ST_INVALID = 3'd4
  } status_e_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] tick;
    logic [23:0] tempo_value;
    logic [63:0] micros;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  status;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_WAIT,
    S_RD,
    S_RD_WAIT,
    S_MUL,
    S_DIV,
    S_DIV_DONE,
    S_US_DIV2,
    S_US_MUL,
    S_US_DIV3,
    S_FINISH,
    S_OUT
  } state_t;

  // Divider request / response
  typedef struct packed {
    logic        start;
    logic [95:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] quot;
    logic [23:0] rem;
  } div_rsp_t;

endpackage

/* src/tempo_map_tick_time_converter_unit.sv */
// Channel | Direction | Handshake        | Payload
// in_     | input     | valid / stall    | tmtc_pkg::in_item_t
// out_    | output    | valid / stall    | tmtc_pkg::out_item_t
// cfg_    | input     | valid / ready    | ticks_per_quarter (16 bits)
// One transaction at a time; the input stalls until the result is taken.
// Lookups run a binary search of log2(points)+1 probes; appends read the last point. Then
// a read and multiply, then at most one pass of the shared 96-step divider for appends and
// tick to micros, up to two passes for micros to tick, and none for tempo at tick. Clear
// and invalid-map transactions go straight to the result. rst_n is synchronous and
// restores the single default point; the input stalls after reset while entry zero is
// rewritten, and the table itself needs no clearing pass.
module tempo_map_tick_time_converter_unit #(
  parameter int unsigned MAX_TEMPO_POINTS = tmtc_pkg::MaxPointsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tmtc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tmtc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  localparam int unsigned IW = $clog2(MAX_TEMPO_POINTS);
  localparam int unsigned CW = $clog2(MAX_TEMPO_POINTS + 1);

  // Point table
  logic [31:0] mem_tick  [MAX_TEMPO_POINTS];
  logic [63:0] mem_time  [MAX_TEMPO_POINTS];
  logic [23:0] mem_tempo [MAX_TEMPO_POINTS];
  logic [31:0] rd_tick;
  logic [63:0] rd_time;
  logic [23:0] rd_tempo;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_tick;
  logic [63:0]   wr_time;
  logic [23:0]   wr_tempo;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_tick[wr_addr]  <= wr_tick;
      mem_time[wr_addr]  <= wr_time;
      mem_tempo[wr_addr] <= wr_tempo;
    end
    rd_tick  <= mem_tick[rd_addr];
    rd_time  <= mem_time[rd_addr];
    rd_tempo <= mem_tempo[rd_addr];
  end

  tmtc_pkg::state_t state_r, state_nxt;
  tmtc_pkg::in_item_t item_r, item_nxt;
  tmtc_pkg::out_item_t res_r, res_nxt;
  logic [15:0]   tpq_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] mid;
  logic [IW-1:0] p_r, p_nxt;
  logic [31:0]   ptick_r, ptick_nxt;
  logic [63:0]   ptime_r, ptime_nxt;
  logic [23:0]   ptempo_r, ptempo_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [63:0]   quot_r, quot_nxt;
  tmtc_pkg::div_req_t dreq;
  tmtc_pkg::div_rsp_t drsp;
  logic          valid_map;
  logic          lt_key;
  logic [64:0]   sum;
  logic [31:0]   dt;
  logic [63:0]   dus;
  logic          rst_fix_r;
  logic          in_take;

  tmtc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign valid_map = (tpq_r != 16'd0) && ((tpq_r & tmtc_pkg::SmpteFlag) == 16'd0);
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign lt_key    = (item_r.mode == tmtc_pkg::MODE_US2T) ? (item_r.micros < rd_time)
                                                          : (item_r.tick < rd_tick);
  assign dt        = item_r.tick - ptick_r;
  assign dus       = item_r.micros - ptime_r;
  assign sum       = {1'b0, ptime_r} + {1'b0, drsp.quot[63:0]};
  assign in_take   = in_valid && !in_stall;

  // Configuration register
  assign cfg_ready = (state_r == tmtc_pkg::S_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpq_r <= tmtc_pkg::TpqReset;
    end else if (cfg_valid && cfg_ready) begin
      tpq_r <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmtc_pkg::S_IDLE: begin
        if (in_take) begin
          if (in_data.mode == tmtc_pkg::MODE_APPEND) begin
            state_nxt = valid_map ? tmtc_pkg::S_RD : tmtc_pkg::S_OUT;
          end else if (in_data.mode == tmtc_pkg::MODE_T2US ||
                       in_data.mode == tmtc_pkg::MODE_US2T ||
                       in_data.mode == tmtc_pkg::MODE_TEMPO) begin
            state_nxt = valid_map ? tmtc_pkg::S_SRCH : tmtc_pkg::S_OUT;
          end else begin
            state_nxt = tmtc_pkg::S_OUT;
          end
        end
      end
      tmtc_pkg::S_SRCH:      state_nxt = (lo_r < hi_r) ? tmtc_pkg::S_SRCH_WAIT
                                                       : tmtc_pkg::S_RD;
      tmtc_pkg::S_SRCH_WAIT: state_nxt = tmtc_pkg::S_SRCH;
      tmtc_pkg::S_RD:        state_nxt = tmtc_pkg::S_RD_WAIT;
      tmtc_pkg::S_RD_WAIT:   state_nxt = tmtc_pkg::S_MUL;
      tmtc_pkg::S_MUL:       state_nxt = tmtc_pkg::S_FINISH;
      tmtc_pkg::S_FINISH: begin
        state_nxt = tmtc_pkg::S_OUT;
        if (item_r.mode == tmtc_pkg::MODE_T2US) begin
          state_nxt = tmtc_pkg::S_DIV;
        end else if (item_r.mode == tmtc_pkg::MODE_US2T) begin
          if (ptempo_r != 24'd0 && item_r.micros >= ptime_r) begin
            state_nxt = tmtc_pkg::S_US_DIV2;
          end
        end else if (item_r.mode == tmtc_pkg::MODE_APPEND) begin
          if (item_r.tempo_value != 24'd0 && item_r.tick > ptick_r &&
              cnt_r < CW'(MAX_TEMPO_POINTS)) begin
            state_nxt = tmtc_pkg::S_DIV;
          end
        end
      end
      tmtc_pkg::S_DIV:       state_nxt = drsp.done ? tmtc_pkg::S_DIV_DONE : tmtc_pkg::S_DIV;
      tmtc_pkg::S_DIV_DONE:  state_nxt = tmtc_pkg::S_OUT;
      tmtc_pkg::S_US_DIV2:   state_nxt = drsp.done ? tmtc_pkg::S_US_MUL : tmtc_pkg::S_US_DIV2;
      tmtc_pkg::S_US_MUL:    state_nxt = (quot_r[63:33] != 31'd0) ? tmtc_pkg::S_OUT
                                                                  : tmtc_pkg::S_US_DIV3;
      tmtc_pkg::S_US_DIV3:   state_nxt = drsp.done ? tmtc_pkg::S_DIV_DONE : tmtc_pkg::S_US_DIV3;
      tmtc_pkg::S_OUT:       state_nxt = out_stall ? tmtc_pkg::S_OUT : tmtc_pkg::S_IDLE;
      default:               state_nxt = tmtc_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    item_nxt   = item_r;
    res_nxt    = res_r;
    cnt_nxt    = cnt_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    p_nxt      = p_r;
    ptick_nxt  = ptick_r;
    ptime_nxt  = ptime_r;
    ptempo_nxt = ptempo_r;
    acc_nxt    = acc_r;
    quot_nxt   = quot_r;
    rd_addr    = p_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_tick    = '0;
    wr_time    = '0;
    wr_tempo   = tmtc_pkg::DefaultTempo;
    dreq       = '0;
    case (state_r)
      tmtc_pkg::S_IDLE: begin
        if (in_take) begin
          item_nxt = in_data;
          res_nxt  = '0;
          lo_nxt   = '0;
          hi_nxt   = cnt_r;
          p_nxt    = IW'(cnt_r - CW'(1));
          case (in_data.mode)
            tmtc_pkg::MODE_CLEAR: begin
              wr_en   = 1'b1;
              cnt_nxt = CW'(1);
            end
            tmtc_pkg::MODE_APPEND, tmtc_pkg::MODE_T2US, tmtc_pkg::MODE_US2T: begin
              if (!valid_map) res_nxt.status = tmtc_pkg::ST_INVALID;
            end
            tmtc_pkg::MODE_TEMPO: begin
              if (!valid_map) begin
                res_nxt.status = tmtc_pkg::ST_INVALID;
                res_nxt.value  = 64'(tmtc_pkg::DefaultTempo);
              end
            end
            default: ;
          endcase
        end
      end
      tmtc_pkg::S_SRCH: begin
        rd_addr = IW'(mid);
        if (lo_r >= hi_r) begin
          p_nxt   = (lo_r == '0) ? '0 : IW'(lo_r - CW'(1));
          rd_addr = p_nxt;
        end
      end
      tmtc_pkg::S_SRCH_WAIT: begin
        if (lt_key) hi_nxt = mid;
        else        lo_nxt = mid + CW'(1);
      end
      tmtc_pkg::S_RD: rd_addr = p_r;
      tmtc_pkg::S_RD_WAIT: begin
        ptick_nxt  = rd_tick;
        ptime_nxt  = rd_time;
        ptempo_nxt = rd_tempo;
      end
      tmtc_pkg::S_MUL: begin
        // dticks * tempo
        acc_nxt = 64'(dt) * 64'(ptempo_r);
      end
      tmtc_pkg::S_FINISH: begin
        case (item_r.mode)
          tmtc_pkg::MODE_TEMPO: res_nxt.value = 64'(ptempo_r);
          tmtc_pkg::MODE_T2US: begin
            dreq.start    = 1'b1;
            dreq.dividend = 96'(acc_r);
            dreq.divisor  = 24'(tpq_r);
          end
          tmtc_pkg::MODE_US2T: begin
            if (ptempo_r == 24'd0 || item_r.micros < ptime_r) begin
              res_nxt.value = 64'(ptick_r);
            end else begin
              dreq.start    = 1'b1;
              dreq.dividend = 96'(dus);
              dreq.divisor  = ptempo_r;
            end
          end
          default: begin
            if (item_r.tempo_value == 24'd0) begin
              res_nxt.status = tmtc_pkg::ST_ZERO;
            end else if (item_r.tick < ptick_r) begin
              res_nxt.status = tmtc_pkg::ST_ORDER;
            end else if (item_r.tick == ptick_r) begin
              wr_en    = 1'b1;
              wr_addr  = p_r;
              wr_tick  = ptick_r;
              wr_time  = ptime_r;
              wr_tempo = item_r.tempo_value;
            end else if (cnt_r >= CW'(MAX_TEMPO_POINTS)) begin
              res_nxt.status = tmtc_pkg::ST_FULL;
            end else begin
              dreq.start    = 1'b1;
              dreq.dividend = 96'(acc_r);
              dreq.divisor  = 24'(tpq_r);
            end
          end
        endcase
      end
      tmtc_pkg::S_US_DIV2: begin
        if (drsp.done) begin
          quot_nxt = drsp.quot[63:0];
          // remainder * division
          acc_nxt  = 64'(drsp.rem) * 64'(tpq_r);
        end
      end
      tmtc_pkg::S_US_MUL: begin
        if (quot_r[63:33] != 31'd0) begin
          res_nxt.value = 64'hFFFF_FFFF;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = 96'(acc_r);
          dreq.divisor  = ptempo_r;
          // tick + q * division, at most 49 bits
          quot_nxt      = 64'(ptick_r) + 64'(49'(quot_r[32:0]) * 49'(tpq_r));
        end
      end
      tmtc_pkg::S_DIV_DONE: begin
        if (item_r.mode == tmtc_pkg::MODE_US2T) begin
          acc_nxt = quot_r + drsp.quot[63:0];
          res_nxt.value = (acc_nxt[63:32] != 32'd0) ? 64'hFFFF_FFFF : acc_nxt;
        end else begin
          res_nxt.value = sum[64] ? '1 : sum[63:0];
          if (item_r.mode == tmtc_pkg::MODE_APPEND) begin
            res_nxt.value = '0;
            wr_en    = 1'b1;
            wr_addr  = IW'(cnt_r);
            wr_tick  = item_r.tick;
            wr_time  = sum[64] ? '1 : sum[63:0];
            wr_tempo = item_r.tempo_value;
            cnt_nxt  = cnt_r + CW'(1);
          end
        end
      end
      default: ;
    endcase
    // Restore the default point in entry zero right after reset
    if (rst_fix_r) begin
      wr_en    = 1'b1;
      wr_addr  = '0;
      wr_tick  = '0;
      wr_time  = '0;
      wr_tempo = tmtc_pkg::DefaultTempo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmtc_pkg::S_IDLE;
      cnt_r   <= CW'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    p_r      <= p_nxt;
    ptick_r  <= ptick_nxt;
    ptime_r  <= ptime_nxt;
    ptempo_r <= ptempo_nxt;
    acc_r    <= acc_nxt;
    quot_r   <= quot_nxt;
  end

  // Entry zero is rewritten in the first cycle after reset
  always_ff @(posedge clk) begin
    rst_fix_r <= !rst_n;
  end

  assign in_stall  = (state_r != tmtc_pkg::S_IDLE) || rst_fix_r;
  assign out_valid = (state_r == tmtc_pkg::S_OUT);
  assign out_data  = res_r;

  // Fill count never leaves 1..MAX
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CW'(MAX_TEMPO_POINTS)))
    else $error("point count out of range");
  // Busy means no input accept
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tmtc_pkg::S_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  // A result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped under stall");

endmodule

/* src/tmtc_div.sv */
module tmtc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tmtc_pkg::div_req_t req,
  output tmtc_pkg::div_rsp_t rsp
);

  logic [95:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [24:0] trial;

  // One restoring step per cycle, 96 steps
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[23:0], q_r[95]};
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd96;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[94:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[94:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[23:0];

endmodule
